// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTCM3 frame finder RTL.
// Needs nothing else; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define RTCM_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Same check, also active while reset is asserted.
`define RTCM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/rtcm_pkg.sv =====
// Constants, result type and CRC-24Q byte update for the RTCM3 frame finder.
// No dependencies; imported by every module of the block.
`default_nettype none

package rtcm_pkg;

    localparam logic [7:0]  PREAMBLE      = 8'hD3;
    localparam logic [24:0] CRC_POLY      = 25'h1864CFB;
    localparam logic [11:0] RESERVED_TYPE = 12'd999;
    localparam logic [10:0] FRAME_EXTRA   = 11'd6;
    localparam logic [10:0] HEADER_BYTES  = 11'd3;
    localparam logic [10:0] TYPE_HI_INDEX = 11'd3;
    localparam logic [10:0] TYPE_LO_INDEX = 11'd4;

    localparam logic STATUS_ACCEPTED = 1'b0;
    localparam logic STATUS_RESERVED = 1'b1;

    typedef struct packed {
        logic        valid;
        logic [11:0] frame_type;
        logic [10:0] frame_len;
        logic        status;
    } rtcm_result_t;

    // One byte of CRC-24Q, most significant bit first.
    function automatic logic [23:0] crc24q_byte(input logic [23:0] crc, input logic [7:0] b);
        logic [24:0] c;
        c = {1'b0, crc ^ {b, 16'h0000}};
        for (int k = 0; k < 8; k++) begin
            c = {c[23:0], 1'b0};
            if (c[24]) begin
                c = c ^ CRC_POLY;
            end
        end
        return c[23:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rtcm3_frame_finder.sv =====
// RTCM3 frame finder: byte input channel, config write channel and report output.
// Depends on rtcm_pkg, rtcm_parser and rtcm_out_buf.
//
// Usage:
//   s_valid/s_ready/s_byte_in carry the received byte stream, one byte per
//   transaction. The block hunts for the 0xD3 preamble, checks CRC-24Q and
//   filters by message type.
//   cfg_valid/cfg_ready/cfg_wdata write the wanted message type (0 = any);
//   cfg_ready is always high. Write it only while no frame is in progress.
//   m_valid/m_ready carry one report per good, matching frame: m_frame_type,
//   m_frame_len (payload + 6) and m_status (1 for type 999).
// Timing:
//   A byte is taken every cycle while s_ready is high; the parser state updates
//   in the cycle of the transaction, and the report for the last CRC byte is
//   registered in the output buffer and shown on m_valid after earlier reports.
// Reset (aresetn low, synchronous): hunting state, filter 0, no reports.
// Stalls: a two-entry output buffer holds reports while m_ready is low;
//   s_ready drops only when both entries are full.
`default_nettype none

module rtcm3_frame_finder
    import rtcm_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_byte_in,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [11:0]  cfg_wdata,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [11:0]       m_frame_type,
    output logic [10:0]       m_frame_len,
    output logic              m_status
);

    rtcm_result_t result;
    logic         buf_can_accept;

    assign s_ready   = buf_can_accept;
    assign cfg_ready = 1'b1;

    rtcm_parser u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .byte_valid      (s_valid && buf_can_accept),
        .byte_in         (s_byte_in),
        .cfg_write       (cfg_valid),
        .cfg_wanted_type (cfg_wdata),
        .result          (result)
    );

    rtcm_out_buf u_out_buf (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push_data    (result),
        .can_accept   (buf_can_accept),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_type (m_frame_type),
        .m_frame_len  (m_frame_len),
        .m_status     (m_status)
    );

endmodule

`default_nettype wire

// ===== rtl/rtcm_parser.sv =====
// Frame hunting state machine with running CRC-24Q and type filter.
// Depends on rtcm_pkg; produces at most one result per accepted byte.
`default_nettype none

module rtcm_parser
    import rtcm_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         byte_valid,
    input  wire logic [7:0]   byte_in,
    input  wire logic         cfg_write,
    input  wire logic [11:0]  cfg_wanted_type,
    output rtcm_result_t      result
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN1,
        PH_LEN2,
        PH_BODY,
        PH_CRC
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [9:0]   payload_len_reg, payload_len_next;
    logic [10:0]  byte_index_reg, byte_index_next;
    logic [23:0]  crc_accum_reg, crc_accum_next;
    logic [23:0]  received_crc_reg, received_crc_next;
    logic [11:0]  type_reg, type_next;
    logic [11:0]  wanted_type_reg;

    logic [23:0]  crc_update;
    logic [10:0]  index_inc;
    logic [10:0]  frame_len;

    assign crc_update = crc24q_byte(crc_accum_reg, byte_in);
    assign index_inc  = byte_index_reg + 11'd1;
    assign frame_len  = {1'b0, payload_len_reg} + FRAME_EXTRA;

    always_comb begin
        phase_next        = phase_reg;
        payload_len_next  = payload_len_reg;
        byte_index_next   = byte_index_reg;
        crc_accum_next    = crc_accum_reg;
        received_crc_next = received_crc_reg;
        type_next         = type_reg;
        result            = '0;

        // The type field is picked up by position, even out of CRC bytes
        // when the payload is shorter than two bytes.
        if (phase_reg != PH_HUNT) begin
            if (byte_index_reg == TYPE_HI_INDEX) begin
                type_next = {byte_in, 4'h0};
            end else if (byte_index_reg == TYPE_LO_INDEX) begin
                type_next = {type_reg[11:4], byte_in[7:4]};
            end
        end

        unique case (phase_reg)
            PH_LEN1: begin
                payload_len_next = {byte_in[1:0], 8'h00};
                crc_accum_next   = crc_update;
                byte_index_next  = 11'd2;
                phase_next       = PH_LEN2;
            end
            PH_LEN2: begin
                payload_len_next  = {payload_len_reg[9:8], byte_in};
                crc_accum_next    = crc_update;
                byte_index_next   = HEADER_BYTES;
                received_crc_next = '0;
                phase_next = ({payload_len_reg[9:8], byte_in} == 10'd0) ? PH_CRC : PH_BODY;
            end
            PH_BODY: begin
                crc_accum_next  = crc_update;
                byte_index_next = index_inc;
                if (index_inc >= {1'b0, payload_len_reg} + HEADER_BYTES) begin
                    phase_next = PH_CRC;
                end
            end
            PH_CRC: begin
                received_crc_next = {received_crc_reg[15:0], byte_in};
                byte_index_next   = index_inc;
                if (index_inc >= frame_len) begin
                    phase_next      = PH_HUNT;
                    byte_index_next = '0;
                    if (received_crc_next == crc_accum_reg) begin
                        result.frame_len = frame_len;
                        if (type_next == RESERVED_TYPE) begin
                            result.valid      = 1'b1;
                            result.frame_type = RESERVED_TYPE;
                            result.status     = STATUS_RESERVED;
                        end else if (wanted_type_reg == 12'd0 ||
                                     type_next == wanted_type_reg) begin
                            result.valid      = 1'b1;
                            result.frame_type = type_next;
                            result.status     = STATUS_ACCEPTED;
                        end
                    end
                end
            end
            default: begin
                phase_next = PH_HUNT;
                if (byte_in == PREAMBLE) begin
                    crc_accum_next    = crc24q_byte(24'h000000, byte_in);
                    byte_index_next   = 11'd1;
                    payload_len_next  = '0;
                    received_crc_next = '0;
                    type_next         = '0;
                    phase_next        = PH_LEN1;
                end
            end
        endcase

        if (!byte_valid) begin
            result.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HUNT;
            payload_len_reg  <= '0;
            byte_index_reg   <= '0;
            crc_accum_reg    <= '0;
            received_crc_reg <= '0;
            type_reg         <= '0;
            wanted_type_reg  <= '0;
        end else begin
            if (byte_valid) begin
                phase_reg        <= phase_next;
                payload_len_reg  <= payload_len_next;
                byte_index_reg   <= byte_index_next;
                crc_accum_reg    <= crc_accum_next;
                received_crc_reg <= received_crc_next;
                type_reg         <= type_next;
            end
            if (cfg_write) begin
                wanted_type_reg <= cfg_wanted_type;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rtcm_out_buf.sv =====
// Two-entry output register with skid stage for the frame reports.
// Depends on rtcm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rtcm_out_buf
    import rtcm_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  rtcm_result_t      push_data,
    output logic              can_accept,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [11:0]       m_frame_type,
    output logic [10:0]       m_frame_len,
    output logic              m_status
);

    logic         out_valid_reg;
    logic         skid_valid_reg;
    logic [11:0]  out_type_reg,  skid_type_reg;
    logic [10:0]  out_len_reg,   skid_len_reg;
    logic         out_status_reg, skid_status_reg;
    logic         pop;
    logic         push;

    assign pop        = out_valid_reg && m_ready;
    assign push       = push_data.valid;
    assign can_accept = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (pop) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (push) begin
                if (!out_valid_reg || pop) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers follow the same decisions and need no reset.
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_type_reg   <= skid_type_reg;
                out_len_reg    <= skid_len_reg;
                out_status_reg <= skid_status_reg;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_type_reg   <= push_data.frame_type;
                out_len_reg    <= push_data.frame_len;
                out_status_reg <= push_data.status;
            end else begin
                skid_type_reg   <= push_data.frame_type;
                skid_len_reg    <= push_data.frame_len;
                skid_status_reg <= push_data.status;
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_frame_type = out_type_reg;
    assign m_frame_len  = out_len_reg;
    assign m_status     = out_status_reg;

    `RTCM_ASSERT(a_skid_behind_out, aclk, aresetn, skid_valid_reg |-> out_valid_reg, "skid entry without output entry")
    `RTCM_ASSERT(a_no_push_when_full, aclk, aresetn, skid_valid_reg |-> !push, "report pushed while buffer full")
    `RTCM_ASSERT(a_push_lands, aclk, aresetn, (push && !skid_valid_reg) |=> out_valid_reg, "pushed report lost")
    `RTCM_ASSERT(a_drain, aclk, aresetn, (pop && !push && !skid_valid_reg) |=> !out_valid_reg, "report repeated after transaction")

endmodule

`default_nettype wire

// ===== test/rtcm3_frame_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the RTCM3 frame finder: tracks the byte stream and filter writes,
// predicts each frame report and compares it with the report channel.
// Depends on rtcm_pkg for the constants.

module rtcm3_frame_checker
    import rtcm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [11:0] cfg_wdata,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [11:0] m_frame_type,
    input  logic [10:0] m_frame_len,
    input  logic        m_status,
    output int          fail_count,
    output int          reports_due,
    output logic        frame_open
);

    typedef enum logic [2:0] {
        SEEK_SYNC  = 3'd0,
        GET_LEN_HI = 3'd1,
        GET_LEN_LO = 3'd2,
        GET_BODY   = 3'd3,
        GET_CRC    = 3'd4
    } parse_state_e;

    typedef struct packed {
        logic [11:0] frame_type;
        logic [10:0] frame_len;
        logic        status;
    } frame_report_t;

    parse_state_e  parse_state;
    logic [9:0]    body_len;
    logic [10:0]   byte_count;
    logic [23:0]   crc_run;
    logic [23:0]   crc_rx;
    logic [11:0]   type_bits;
    logic [11:0]   type_filter;
    frame_report_t report_q[$];
    frame_report_t want;

    function automatic logic [23:0] crc24q_update(input logic [23:0] crc,
                                                  input logic [7:0] data);
        logic [23:0] r;
        logic        fb;
        int          i;
        r = crc;
        for (i = 7; i >= 0; i--) begin
            fb = r[23] ^ data[i];
            r = {r[22:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY[23:0];
            end
        end
        return r;
    endfunction

    task automatic advance_parser(input logic [7:0] b);
        frame_report_t rep;
        logic [10:0]   flen;
        // The type is picked up at fixed frame offsets, even when those bytes
        // already belong to the CRC of a short frame.
        if (parse_state != SEEK_SYNC) begin
            if (byte_count == 11'd3) begin
                type_bits = {b, 4'h0};
            end else if (byte_count == 11'd4) begin
                type_bits = {type_bits[11:4], b[7:4]};
            end
        end
        case (parse_state)
            GET_LEN_HI: begin
                body_len    = {b[1:0], 8'h00};
                crc_run     = crc24q_update(crc_run, b);
                byte_count  = 11'd2;
                parse_state = GET_LEN_LO;
            end
            GET_LEN_LO: begin
                body_len    = {body_len[9:8], b};
                crc_run     = crc24q_update(crc_run, b);
                byte_count  = 11'd3;
                crc_rx      = 24'h0;
                parse_state = (body_len == 10'd0) ? GET_CRC : GET_BODY;
            end
            GET_BODY: begin
                crc_run    = crc24q_update(crc_run, b);
                byte_count = byte_count + 11'd1;
                if (byte_count >= {1'b0, body_len} + 11'd3) begin
                    parse_state = GET_CRC;
                end
            end
            GET_CRC: begin
                crc_rx     = {crc_rx[15:0], b};
                byte_count = byte_count + 11'd1;
                flen       = {1'b0, body_len} + FRAME_EXTRA;
                if (byte_count >= flen) begin
                    parse_state = SEEK_SYNC;
                    byte_count  = 11'd0;
                    if (crc_rx == crc_run) begin
                        rep.frame_len = flen;
                        if (type_bits == RESERVED_TYPE) begin
                            rep.frame_type = RESERVED_TYPE;
                            rep.status     = STATUS_RESERVED;
                            report_q.insert(report_q.size(), rep);
                        end else if (type_filter == 12'd0 || type_bits == type_filter) begin
                            rep.frame_type = type_bits;
                            rep.status     = STATUS_ACCEPTED;
                            report_q.insert(report_q.size(), rep);
                        end
                    end
                end
            end
            default: begin
                parse_state = SEEK_SYNC;
                if (b == PREAMBLE) begin
                    crc_run     = crc24q_update(24'h0, b);
                    byte_count  = 11'd1;
                    body_len    = 10'd0;
                    crc_rx      = 24'h0;
                    type_bits   = 12'd0;
                    parse_state = GET_LEN_HI;
                end
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            parse_state = SEEK_SYNC;
            body_len    = 10'd0;
            byte_count  = 11'd0;
            crc_run     = 24'h0;
            crc_rx      = 24'h0;
            type_bits   = 12'd0;
            type_filter = 12'd0;
            fail_count  = 0;
            report_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                advance_parser(s_byte_in);
            end
            if (cfg_valid && cfg_ready) begin
                type_filter = cfg_wdata;
            end
            if (m_valid && m_ready) begin
                if (report_q.size() == 0) begin
                    $error("unexpected report: frame_type %0d frame_len %0d status %0d",
                           m_frame_type, m_frame_len, m_status);
                    fail_count++;
                end else begin
                    want = report_q.pop_front();
                    if (m_frame_type !== want.frame_type) begin
                        $error("frame_type: expected %0d, actual %0d",
                               want.frame_type, m_frame_type);
                        fail_count++;
                    end
                    if (m_frame_len !== want.frame_len) begin
                        $error("frame_len: expected %0d, actual %0d",
                               want.frame_len, m_frame_len);
                        fail_count++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_status);
                        fail_count++;
                    end
                end
            end
        end
        reports_due = report_q.size();
        frame_open  = (parse_state != SEEK_SYNC);
    end

endmodule

// ===== test/tb_rtcm3_frame_finder.sv =====
`timescale 1ns / 100ps
// Top-level testbench for rtcm3_frame_finder: clock, reset, byte and filter stimulus,
// report-side back-pressure and the verdict. Depends on rtcm_pkg and rtcm3_frame_checker.

module tb_rtcm3_frame_finder
    import rtcm_pkg::*;
;

    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_BYTES  = 600;
    localparam int PHASE_COUNT   = 6;
    localparam int MAX_BODY      = 1023;
    localparam logic [11:0] FILTER_ANY = 12'd0;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_byte_in;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [11:0] cfg_wdata;
    logic        m_valid;
    logic        m_ready;
    logic [11:0] m_frame_type;
    logic [10:0] m_frame_len;
    logic        m_status;

    int          fail_count;
    int          reports_due;
    logic        frame_open;

    bit          steady_flow = 1'b0;
    int          idle_cycles = 0;
    int          bytes_sent  = 0;
    logic [7:0]  frame_q[$];
    logic [11:0] filter_plan [0:PHASE_COUNT-1];

    always #4 aclk = ~aclk;

    rtcm3_frame_finder u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte_in    (s_byte_in),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_wdata    (cfg_wdata),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_type (m_frame_type),
        .m_frame_len  (m_frame_len),
        .m_status     (m_status)
    );

    rtcm3_frame_checker u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte_in    (s_byte_in),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_wdata    (cfg_wdata),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_type (m_frame_type),
        .m_frame_len  (m_frame_len),
        .m_status     (m_status),
        .fail_count   (fail_count),
        .reports_due  (reports_due),
        .frame_open   (frame_open)
    );

    function automatic int pick_gap();
        if (steady_flow) begin
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    // Called and returning at a falling edge; valid stays up after the
    // transaction so that a back-to-back byte needs no extra assignment.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_byte_in <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[k]) begin
            send_byte(frame_q[k]);
        end
        frame_q.delete();
    endtask

    // Well-formed frame with a correct CRC; the type sits in the first payload bits.
    task automatic build_frame(input int len, input logic [11:0] msg, input logic [5:0] spare);
        logic [9:0]  len_bits;
        logic [23:0] crc;
        logic [7:0]  fill;
        len_bits = len[9:0];
        crc = 24'h0;
        frame_q.delete();
        frame_q.insert(frame_q.size(), PREAMBLE);
        frame_q.insert(frame_q.size(), {spare, len_bits[9:8]});
        frame_q.insert(frame_q.size(), len_bits[7:0]);
        for (int i = 0; i < len; i++) begin
            fill = 8'($urandom_range(0, 255));
            if (i == 0) begin
                frame_q.insert(frame_q.size(), msg[11:4]);
            end else if (i == 1) begin
                frame_q.insert(frame_q.size(), {msg[3:0], fill[3:0]});
            end else begin
                frame_q.insert(frame_q.size(), fill);
            end
        end
        foreach (frame_q[k]) begin
            crc = crc24q_byte(crc, frame_q[k]);
        end
        frame_q.insert(frame_q.size(), crc[23:16]);
        frame_q.insert(frame_q.size(), crc[15:8]);
        frame_q.insert(frame_q.size(), crc[7:0]);
    endtask

    // Flip one bit past the header, so the framing holds but the CRC fails.
    task automatic corrupt_frame();
        int idx;
        int sh;
        idx = $urandom_range(3, frame_q.size() - 1);
        sh  = $urandom_range(0, 7);
        frame_q[idx] = frame_q[idx] ^ (8'h01 << sh);
    endtask

    task automatic hold_off();
        s_valid <= 1'b0;
        while (reports_due != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // The filter may only change with the parser back in preamble search.
    task automatic write_filter(input logic [11:0] value);
        while (frame_open) begin
            send_byte(8'h00);
        end
        hold_off();
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_frame(input logic [11:0] filt);
        int          kind;
        int          len;
        logic [11:0] msg;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end else begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: msg = (filt != FILTER_ANY) ? filt : 12'($urandom_range(0, 4095));
                4, 5:       msg = RESERVED_TYPE;
                6:          msg = 12'd0;
                7:          msg = 12'hFFF;
                default:    msg = 12'($urandom_range(0, 4095));
            endcase
            build_frame(len, msg, 6'($urandom_range(0, 63)));
            if (kind < 22) begin
                corrupt_frame();
            end else if (kind < 30) begin
                // Truncated frame: the following bytes get swallowed as its tail.
                repeat ($urandom_range(1, 3)) void'(frame_q.pop_back());
            end
            send_frame();
        end
    endtask

    // Report side: a random stall, possibly none, before each report.
    initial begin
        int gap;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int phase_start;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_byte_in = 8'h00;
        cfg_valid = 1'b0;
        cfg_wdata = 12'd0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        write_filter(FILTER_ANY);

        // Directed: byte extremes, empty payload with all reserved header bits set,
        // a one-byte payload with a bad CRC, and a reserved-type frame.
        send_byte(8'h00);
        send_byte(8'hFF);
        build_frame(0, 12'd0, 6'h3F);
        send_frame();
        build_frame(1, 12'hABC, 6'h00);
        corrupt_frame();
        send_frame();
        build_frame(2, RESERVED_TYPE, 6'h15);
        send_frame();

        filter_plan = '{FILTER_ANY, 12'hFFF, RESERVED_TYPE, 12'd1, 12'd0, FILTER_ANY};
        filter_plan[4] = 12'($urandom_range(2, 4094));
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_filter(filter_plan[p]);
            steady_flow = (p == 3);
            if (p == 0) begin
                build_frame(MAX_BODY, 12'($urandom_range(0, 4095)), 6'($urandom_range(0, 63)));
                send_frame();
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < RANDOM_BYTES / PHASE_COUNT) begin
                random_frame(filter_plan[p]);
                if ($urandom_range(0, 39) == 0) begin
                    hold_off();
                end
                if (p != 3 && $urandom_range(0, 15) == 0) begin
                    steady_flow = !steady_flow;
                end
            end
        end
        steady_flow = 1'b0;

        hold_off();
        repeat (16) @(negedge aclk);
        if (fail_count == 0 && reports_due == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== rtcm3_frame_finder.f =====
+incdir+rtl
rtl/rtcm_pkg.sv
rtl/rtcm_parser.sv
rtl/rtcm_out_buf.sv
rtl/rtcm3_frame_finder.sv
test/rtcm3_frame_checker.sv
test/tb_rtcm3_frame_finder.sv
